/* rtl/rgb_gray_box3x3_smoother_core_defines.svh */
// Assertion macros used by the checker file of the smoother core.
`ifndef RGB_GRAY_BOX3X3_SMOOTHER_CORE_DEFINES_SVH
`define RGB_GRAY_BOX3X3_SMOOTHER_CORE_DEFINES_SVH

// Check a property at every edge outside reset.
`define RGBSM_ASSERT_NOW(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define RGBSM_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rgbsm_pkg.sv */
package rgbsm_pkg;

  // Default line buffer depth
  localparam int MAX_WIDTH_DEF = 1024;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 16;
  localparam int OUT_COL_W  = 10;
  localparam int IMG_W_W    = 11;
  localparam int EMIT_W     = 26;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int IN_DATA_W  = 3 * PIX_W;
  localparam int OUT_PAD_W  = 6;
  localparam int OUT_DATA_W = 2 * PIX_W + ROW_W + OUT_COL_W + OUT_PAD_W;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  // Reciprocal constants: x/3 and x/9 exact over the sum ranges used
  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;
  localparam int DIV9_MUL = 3641;
  localparam int DIV9_SH  = 15;

  // Item entering the line buffer stage
  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] orow;
  } pos_t;

  // Sum of three 8-bit components divided by three, truncated
  function automatic logic [PIX_W-1:0] div3(input logic [9:0] sum);
    logic [20:0] prod;
    prod = 21'(sum) * 21'(DIV3_MUL);
    return prod[DIV3_SH +: PIX_W];
  endfunction

  // Sum of nine 8-bit values divided by nine, truncated
  function automatic logic [PIX_W-1:0] div9(input logic [11:0] sum);
    logic [23:0] prod;
    prod = 24'(sum) * 24'(DIV9_MUL);
    return prod[DIV9_SH +: PIX_W];
  endfunction

endpackage

/* rtl/rgb_gray_box3x3_smoother_core.sv */
// Channel | Ports                      | Contents
// --------+----------------------------+------------------------------------------------
// in      | in_tvalid/tready/tdata/tuser | RGB pixel, or flush tick in tuser
// out     | out_tvalid/tready/tdata/tlast| smoothed gray with row, column and frame peak
// cfg     | cfg_we/addr/wdata          | image width and height, write only
//
// One item per cycle unless the output or a configuration write stalls the input.
// The rate is set by the line buffer, one read and one write-back per pixel per cycle.
// The whole pipeline freezes while a finished result waits on out_tready.
// in_tready drops in the cycle of a configuration write and the cycle after it.
// Reset is synchronous and active low; the line buffers need no clearing pass.
module rgb_gray_box3x3_smoother_core import rgbsm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // red, green, blue
  input  logic                  in_tuser,   // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // smoothed_gray, out_row, out_col, frame_peak
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int TW = WW + ROW_W;
  localparam int W_EFF_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int TOTAL_RST = W_EFF_RST * RESET_HEIGHT;

  logic [IMG_W_W-1:0] img_width_r;
  logic [ROW_W-1:0]   img_height_r;
  logic [WW-1:0]      w_eff_r, w_eff_nxt;
  logic [ROW_W-1:0]   h_eff_r, h_eff_nxt;
  logic [TW-1:0]      total_r, total_nxt;
  logic               cfg_hold_r;

  logic               adv, accept, rd_en, s1_valid, wr_en, out_valid, out_last;
  logic [CW-1:0]      rd_addr, s1_col, s1_ocol, wr_addr;
  logic [LINE_W-1:0]  rd_data, wr_data;
  pos_t               s1;
  logic [PIX_W-1:0]   out_gray, out_peak;
  logic [ROW_W-1:0]   out_row;
  logic [OUT_COL_W-1:0] out_col;

  // Clamp the registers to usable values and precompute the frame size
  always_comb begin
    if (img_width_r == '0) begin
      w_eff_nxt = WW'(1);
    end else if (img_width_r > MAX_WIDTH) begin
      w_eff_nxt = WW'(MAX_WIDTH);
    end else begin
      w_eff_nxt = WW'(img_width_r);
    end
    h_eff_nxt = (img_height_r == '0) ? 16'd1 : img_height_r;
    total_nxt = TW'(w_eff_nxt) * TW'(h_eff_nxt);
  end

  // Configuration registers and derived frame values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= IMG_W_W'(RESET_WIDTH);
      img_height_r <= ROW_W'(RESET_HEIGHT);
      w_eff_r      <= WW'(W_EFF_RST);
      h_eff_r      <= ROW_W'(RESET_HEIGHT);
      total_r      <= TW'(TOTAL_RST);
      cfg_hold_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: img_height_r <= cfg_wdata[ROW_W-1:0];
          default: ;
        endcase
      end
      w_eff_r    <= w_eff_nxt;
      h_eff_r    <= h_eff_nxt;
      total_r    <= total_nxt;
      cfg_hold_r <= cfg_we;
    end
  end

  // Pipeline moves whenever the output register is free or being drained
  assign adv       = !out_valid || out_tready;
  assign in_tready = adv && !cfg_we && !cfg_hold_r;
  assign accept    = in_tvalid && in_tready;

  rgbsm_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW),
    .WW        (WW),
    .TW        (TW)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .accept   (accept),
    .mode     (in_tuser),
    .red      (in_tdata[PIX_W-1:0]),
    .green    (in_tdata[2*PIX_W-1:PIX_W]),
    .blue     (in_tdata[3*PIX_W-1:2*PIX_W]),
    .w_eff    (w_eff_r),
    .h_eff    (h_eff_r),
    .total    (total_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_col   (s1_col),
    .s1_ocol  (s1_ocol)
  );

  rgbsm_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  rgbsm_win #(
    .CW (CW),
    .WW (WW)
  ) u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_col    (s1_col),
    .s1_ocol   (s1_ocol),
    .w_eff     (w_eff_r),
    .h_eff     (h_eff_r),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_valid),
    .out_gray  (out_gray),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_last  (out_last),
    .out_peak  (out_peak)
  );

  assign out_tvalid = out_valid;
  assign out_tlast  = out_last;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_peak, out_col, out_row, out_gray};

endmodule

/* rtl/rgbsm_linebuf.sv */
module rgbsm_linebuf import rgbsm_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int AW    = $clog2(MAX_WIDTH_DEF)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [LINE_W-1:0] wr_data,
  output logic [LINE_W-1:0] rd_data
);

  // Entry layout: [15:8] two rows above, [7:0] one row above
  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; forward a write to the same entry on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/rgbsm_pos.sv */
module rgbsm_pos import rgbsm_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW = $clog2(MAX_WIDTH),
  parameter int WW = $clog2(MAX_WIDTH + 1),
  parameter int TW = WW + ROW_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             accept,
  input  logic             mode,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  input  logic [WW-1:0]    w_eff,
  input  logic [ROW_W-1:0] h_eff,
  input  logic [TW-1:0]    total,
  output logic             rd_en,
  output logic [CW-1:0]    rd_addr,
  output logic             s1_valid,
  output pos_t             s1,
  output logic [CW-1:0]    s1_col,
  output logic [CW-1:0]    s1_ocol
);

  localparam int CMPW = (TW > EMIT_W) ? TW : EMIT_W;

  logic [CW-1:0]     in_col_r, col_nxt;
  logic [ROW_W-1:0]  in_row_r, row_nxt;
  logic [EMIT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic              s1_valid_r;
  pos_t              s1_r;
  logic [CW-1:0]     s1_col_r, s1_ocol_r;

  logic              tail, take, emit, wrap, last;
  logic [9:0]        rgb_sum;
  logic [PIX_W-1:0]  gray;
  logic [CW-1:0]     ocol;
  logic [ROW_W-1:0]  orow;

  // Classify the item and work out the pixel it releases
  always_comb begin
    tail    = in_row_r >= h_eff;
    take    = accept && !((mode == MODE_FLUSH) && !tail);
    rgb_sum = 10'(red) + 10'(green) + 10'(blue);
    gray    = tail ? '0 : div3(rgb_sum);
    emit    = (in_row_r >= 16'd2) || ((in_row_r == 16'd1) && (in_col_r != '0));
    if (in_col_r != '0) begin
      ocol = in_col_r - 1'b1;
      orow = in_row_r - 16'd1;
    end else begin
      ocol = CW'(w_eff - 1'b1);
      orow = in_row_r - 16'd2;
    end
    wrap    = (WW'(in_col_r) + WW'(1)) >= w_eff;
    cnt_inc = cnt_r + 1'b1;
    last    = emit && (CMPW'(cnt_inc) >= CMPW'(total));
  end

  // Advance the raster position; restart it after the frame's last result
  always_comb begin
    col_nxt = in_col_r;
    row_nxt = in_row_r;
    cnt_nxt = cnt_r;
    if (take) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end else begin
        if (wrap) begin
          col_nxt = '0;
          row_nxt = in_row_r + 16'd1;
        end else begin
          col_nxt = in_col_r + 1'b1;
        end
        if (emit) begin
          cnt_nxt = cnt_inc;
        end
      end
    end
  end

  // Position state and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      in_col_r <= col_nxt;
      in_row_r <= row_nxt;
      cnt_r    <= cnt_nxt;
      if (adv) begin
        s1_valid_r <= take;
      end
    end
  end

  // Hold the item for the line buffer stage
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r.gray <= gray;
      s1_r.emit <= emit;
      s1_r.last <= last;
      s1_r.orow <= orow;
      s1_col_r  <= in_col_r;
      s1_ocol_r <= ocol;
    end
  end

  assign rd_en    = take;
  assign rd_addr  = in_col_r;
  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;
  assign s1_col   = s1_col_r;
  assign s1_ocol  = s1_ocol_r;

endmodule

/* rtl/rgbsm_win.sv */
module rgbsm_win import rgbsm_pkg::*; #(
  parameter int CW = $clog2(MAX_WIDTH_DEF),
  parameter int WW = $clog2(MAX_WIDTH_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 s1_valid,
  input  pos_t                 s1,
  input  logic [CW-1:0]        s1_col,
  input  logic [CW-1:0]        s1_ocol,
  input  logic [WW-1:0]        w_eff,
  input  logic [ROW_W-1:0]     h_eff,
  input  logic [LINE_W-1:0]    rd_data,
  output logic                 wr_en,
  output logic [CW-1:0]        wr_addr,
  output logic [LINE_W-1:0]    wr_data,
  output logic                 out_valid,
  output logic [PIX_W-1:0]     out_gray,
  output logic [ROW_W-1:0]     out_row,
  output logic [OUT_COL_W-1:0] out_col,
  output logic                 out_last,
  output logic [PIX_W-1:0]     out_peak
);

  typedef struct packed {
    logic [ROW_W-1:0] orow;
    logic [CW-1:0]    ocol;
    logic             last;
    logic             interior;
  } side_t;

  logic [PIX_W-1:0] win_r [9];
  logic             v2_r, v3_r, v4_r, v5_r, out_valid_r;
  side_t            side2_r, side3_r, side4_r, side5_r, side_in;
  logic [PIX_W-1:0] center3_r, center4_r, center5_r;
  logic [9:0]       rs3_r [3];
  logic [11:0]      sum4_r;
  logic [PIX_W-1:0] quot5_r;
  logic [PIX_W-1:0] peak_r, peak_sel, gray_sel;
  logic [PIX_W-1:0] out_gray_r, out_peak_r;
  logic [ROW_W-1:0] out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic             out_last_r;

  // Interior test on the released pixel
  always_comb begin
    side_in.orow     = s1.orow;
    side_in.ocol     = s1_ocol;
    side_in.last     = s1.last;
    side_in.interior = (s1.orow != '0)
                    && ((17'(s1.orow) + 17'd2) <= 17'(h_eff))
                    && (s1_ocol != '0)
                    && (((WW+1)'(s1_ocol) + (WW+1)'(2)) <= (WW+1)'(w_eff));
  end

  // Write back: the row above moves to two above, new gray to the row above
  assign wr_en   = adv && s1_valid;
  assign wr_addr = s1_col;
  assign wr_data = {rd_data[PIX_W-1:0], s1.gray};

  // Pick the result and the running peak
  always_comb begin
    gray_sel = side5_r.interior ? quot5_r : center5_r;
    peak_sel = (side5_r.interior && (quot5_r > peak_r)) ? quot5_r : peak_r;
  end

  // Window, stage valids and peak
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
      peak_r      <= '0;
    end else if (adv) begin
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r*3]     <= win_r[r*3 + 1];
          win_r[r*3 + 1] <= win_r[r*3 + 2];
        end
        win_r[2] <= rd_data[LINE_W-1:PIX_W];
        win_r[5] <= rd_data[PIX_W-1:0];
        win_r[8] <= s1.gray;
      end
      v2_r        <= s1_valid && s1.emit;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
      if (v5_r) begin
        peak_r <= side5_r.last ? '0 : peak_sel;
      end
    end
  end

  // Sum tree, divide and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      side2_r <= side_in;
      for (int r = 0; r < 3; r++) begin
        rs3_r[r] <= 10'(win_r[r*3]) + 10'(win_r[r*3 + 1]) + 10'(win_r[r*3 + 2]);
      end
      side3_r   <= side2_r;
      center3_r <= win_r[4];
      sum4_r    <= 12'(rs3_r[0]) + 12'(rs3_r[1]) + 12'(rs3_r[2]);
      side4_r   <= side3_r;
      center4_r <= center3_r;
      quot5_r   <= div9(sum4_r);
      side5_r   <= side4_r;
      center5_r <= center4_r;
      if (v5_r) begin
        out_gray_r <= gray_sel;
        out_row_r  <= side5_r.orow;
        out_col_r  <= OUT_COL_W'(side5_r.ocol);
        out_last_r <= side5_r.last;
        out_peak_r <= peak_sel;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_gray  = out_gray_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;
  assign out_peak  = out_peak_r;

endmodule

/* rtl/rgbsm_checker.sv */
`include "rgb_gray_box3x3_smoother_core_defines.svh"

module rgbsm_checker import rgbsm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_we
);

  // A stalled result holds
  `RGBSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // No pixel transfer on a configuration write
  `RGBSM_ASSERT_NOW(a_cfg_block, clk, rst_n, cfg_we |-> !in_tready, "input ready during configuration write")

  // Input stays blocked in the cycle after a write while derived frame values settle
  `RGBSM_ASSERT_NEXT(a_cfg_settle, clk, rst_n, cfg_we, !in_tready, "input ready right after configuration write")

  // Input is only taken when the pipeline can move
  `RGBSM_ASSERT_NOW(a_ready_adv, clk, rst_n, in_tready |-> (!out_tvalid || out_tready), "input ready while output stalled")

endmodule

bind rgb_gray_box3x3_smoother_core rgbsm_checker u_rgbsm_checker (.*);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rgbsm_pkg::*;

  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 540;
  localparam int unsigned REPORT_CAP      = 40;
  localparam int ROW_LSB  = PIX_W;
  localparam int COL_LSB  = PIX_W + ROW_W;
  localparam int PEAK_LSB = PIX_W + ROW_W + OUT_COL_W;

  // One transfer on the pixel side
  typedef struct packed {
    mode_t            mode;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_item_t;

  // One smoothed output pixel
  typedef struct packed {
    logic [PIX_W-1:0]     peak;
    logic                 eof;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic [PIX_W-1:0]     gray;
  } smooth_px_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // red, green, blue
  logic                  in_tuser   = 1'b0; // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // smoothed_gray, out_row, out_col, frame_peak
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Predictor state
  logic [PIX_W-1:0] line_prev  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] box_win    [9];
  int unsigned width_reg  = RESET_WIDTH;
  int unsigned height_reg = RESET_HEIGHT;
  int unsigned col_pos    = 0;
  int unsigned row_pos    = 0;
  int unsigned emit_cnt   = 0;
  int unsigned peak_val   = 0;

  // Traffic and bookkeeping
  pixel_item_t pixel_backlog [$];
  smooth_px_t  smooth_due    [$];
  bit          pix_taken      = 1'b0;
  bit          quiet          = 1'b0;
  bit          hold_req       = 1'b0;
  int unsigned send_gap       = 0;
  int unsigned stall_left     = 0;
  int unsigned idle_run       = 0;
  int unsigned items_pushed   = 0;
  int unsigned items_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned frames_seen    = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatch_count = 0;

  rgb_gray_box3x3_smoother_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, none while quiet
  function automatic int unsigned gap_cycles();
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Advance the gray/box pipeline by one transfer; returns 1 when a pixel is due
  function automatic bit predict_smooth(input pixel_item_t px, output smooth_px_t res);
    int unsigned w, h, gray, level, col, orow, ocol, sum;
    int k;
    bit tail, emit;
    w = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    h = (height_reg < 1) ? 1 : height_reg;
    tail = row_pos >= h;
    res = '0;
    // a flush before the frame is complete is dropped
    if (px.mode == MODE_FLUSH && !tail) return 1'b0;
    gray = tail ? 0 : (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;

    // shift the window and rotate the line buffers
    col = (col_pos < MAX_WIDTH_DEF) ? col_pos : 0;
    for (k = 0; k < 3; k++) begin
      box_win[3*k]   = box_win[3*k+1];
      box_win[3*k+1] = box_win[3*k+2];
    end
    box_win[2] = line_prev2[col];
    box_win[5] = line_prev[col];
    box_win[8] = gray[PIX_W-1:0];
    line_prev2[col] = line_prev[col];
    line_prev[col]  = gray[PIX_W-1:0];

    // output lags one row plus one pixel
    emit = (row_pos >= 2) || (row_pos == 1 && col_pos >= 1);
    if (col_pos >= 1) begin
      orow = (row_pos - 1) & 32'hFFFF;
      ocol = col_pos - 1;
    end else begin
      orow = (row_pos - 2) & 32'hFFFF;
      ocol = w - 1;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & 32'hFFFF;
    end else begin
      col_pos++;
    end
    if (!emit) return 1'b0;

    // interior pixels take the box mean, the border passes through
    if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
      sum = 0;
      for (k = 0; k < 9; k++) sum += box_win[k];
      level = sum / 9;
      if (level > peak_val) peak_val = level;
    end else begin
      level = box_win[4];
    end
    emit_cnt = (emit_cnt + 1) & 32'h3FF_FFFF;

    res.gray = level[PIX_W-1:0];
    res.row  = orow[ROW_W-1:0];
    res.col  = ocol[OUT_COL_W-1:0];
    res.eof  = emit_cnt >= h * w;
    res.peak = peak_val[PIX_W-1:0];
    if (res.eof) begin
      col_pos  = 0;
      row_pos  = 0;
      emit_cnt = 0;
      peak_val = 0;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      // cap the log, keep counting
      if (mismatch_count <= REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Check results, then predict from the pixel taken at this edge
  always @(posedge clk) begin : monitor
    pixel_item_t px;
    smooth_px_t  want, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.gray = out_tdata[PIX_W-1:0];
        got.row  = out_tdata[ROW_LSB +: ROW_W];
        got.col  = out_tdata[COL_LSB +: OUT_COL_W];
        got.peak = out_tdata[PEAK_LSB +: PIX_W];
        got.eof  = out_tlast;
        results_seen++;
        if (got.eof) frames_seen++;
        if (smooth_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $error("unexpected result at row %0d col %0d", got.row, got.col);
        end else begin
          want = smooth_due.pop_front();
          check_field("smoothed_gray", want.gray, got.gray);
          check_field("out_row", want.row, got.row);
          check_field("out_col", want.col, got.col);
          check_field("last_of_frame", want.eof, got.eof);
          check_field("frame_peak", want.peak, got.peak);
        end
      end
      pix_taken = in_tvalid && in_tready;
      if (pix_taken) begin
        px.mode  = mode_t'(in_tuser);
        px.red   = in_tdata[PIX_W-1:0];
        px.green = in_tdata[PIX_W +: PIX_W];
        px.blue  = in_tdata[2*PIX_W +: PIX_W];
        items_taken++;
        if (predict_smooth(px, want)) smooth_due.push_back(want);
      end
    end
  end

  // Offer pixels from the backlog; hold each until its transfer
  always @(negedge clk) begin : feed_pixels
    pixel_item_t px;
    if (rst_n && (!in_tvalid || pix_taken)) begin
      if (send_gap > 0 || pixel_backlog.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        px = pixel_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= px.mode;
        in_tdata  <= {px.blue, px.green, px.red};
        send_gap = gap_cycles();
      end
    end
  end

  // Accept results with random stalls; a long hold-off on request
  always @(negedge clk) begin : drain_results
    if (rst_n) begin
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = gap_cycles();
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic void push_item(input mode_t mode, input logic [PIX_W-1:0] r,
                                    input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
    pixel_item_t px;
    px.mode  = mode;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pixel_backlog.push_back(px);
    items_pushed++;
  endfunction

  // Wait until every pixel is taken and every result has left
  task automatic wait_drained();
    while (items_pushed != items_taken || smooth_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    if (idx == REG_IMAGE_WIDTH) width_reg = value & 16'h07FF;
    else height_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  // Idle the block, let the pipeline empty, then load a new frame size
  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] w_raw,
                                input logic [CFG_DATA_W-1:0] h_raw);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, w_raw);
    write_reg(REG_IMAGE_HEIGHT, h_raw);
  endtask

  // One whole frame: data with stray flushes, then the tail of w+1 ticks
  task automatic push_frame(input int unsigned w, input int unsigned h, input bit may_pause);
    int unsigned k, pause_at;
    bit flat;
    pause_at = (may_pause && $urandom_range(0, 3) == 0) ? $urandom_range(0, w*h-1) : w*h;
    flat = ($urandom_range(0, 5) == 0);
    for (k = 0; k < w * h; k++) begin
      if ($urandom_range(0, 19) == 0)
        push_item(MODE_FLUSH, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                  PIX_W'($urandom_range(0, 255)));
      // a saturated frame drives the peak to its top
      if (flat) push_item(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      else push_item(MODE_PIXEL, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                     PIX_W'($urandom_range(0, 255)));
      if (k == pause_at) wait_drained();
    end
    // a data pixel in the tail counts as a flush
    for (k = 0; k <= w; k++)
      push_item(($urandom_range(0, 7) == 0) ? MODE_PIXEL : MODE_FLUSH,
                PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                PIX_W'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int unsigned k, w, h, nframes, random_start;
    logic [CFG_DATA_W-1:0] w_raw;
    for (k = 0; k < MAX_WIDTH_DEF; k++) begin
      line_prev[k]  = '0;
      line_prev2[k] = '0;
    end
    for (k = 0; k < 9; k++) box_win[k] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 4x4 frame: colour extremes, a stray flush, a data pixel in the tail
    set_frame_size(4, 4);
    push_item(MODE_PIXEL, 8'd0, 8'd0, 8'd0);
    push_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(MODE_PIXEL, 8'd255, 8'd0, 8'd0);
    push_item(MODE_PIXEL, 8'd0, 8'd255, 8'd0);
    push_item(MODE_PIXEL, 8'd0, 8'd0, 8'd255);
    push_item(MODE_PIXEL, 8'd254, 8'd1, 8'd2);
    push_item(MODE_FLUSH, 8'd85, 8'd170, 8'd85);
    push_item(MODE_PIXEL, 8'd128, 8'd64, 8'd32);
    push_item(MODE_PIXEL, 8'd1, 8'd1, 8'd1);
    push_item(MODE_PIXEL, 8'd170, 8'd85, 8'd255);
    push_item(MODE_PIXEL, 8'd85, 8'd170, 8'd0);
    push_item(MODE_PIXEL, 8'd255, 8'd255, 8'd254);
    push_item(MODE_PIXEL, 8'd2, 8'd0, 8'd0);
    push_item(MODE_PIXEL, 8'd100, 8'd200, 8'd50);
    push_item(MODE_PIXEL, 8'd255, 8'd128, 8'd0);
    push_item(MODE_PIXEL, 8'd3, 8'd3, 8'd3);
    push_item(MODE_PIXEL, 8'd7, 8'd250, 8'd9);
    push_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(MODE_FLUSH, 8'd255, 8'd255, 8'd255);
    push_item(MODE_PIXEL, 8'd200, 8'd200, 8'd200);
    push_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);

    // zero width and height clamp to 1x1; the first tail tick has nothing due
    set_frame_size(0, 0);
    push_item(MODE_PIXEL, 8'd255, 8'd255, 8'd255);
    push_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);
    push_item(MODE_FLUSH, 8'd0, 8'd0, 8'd0);

    // fill the pipe against a long output hold-off
    random_start = items_pushed;
    set_frame_size(8, 6);
    hold_req = 1'b1;
    push_frame(8, 6, 1'b0);

    // random small frames, some quiet, width written with junk in the upper bits
    while (items_pushed - random_start < RANDOM_ITEMS) begin
      w = $urandom_range(0, 9);
      h = $urandom_range(0, 6);
      w_raw = CFG_DATA_W'(w);
      if ($urandom_range(0, 2) == 0)
        w_raw[CFG_DATA_W-1:IMG_W_W] = (CFG_DATA_W-IMG_W_W)'($urandom_range(1, 31));
      set_frame_size(w_raw, CFG_DATA_W'(h));
      quiet = ($urandom_range(0, 4) == 0);
      nframes = $urandom_range(1, 3);
      for (k = 0; k < nframes; k++) push_frame((w < 1) ? 1 : w, (h < 1) ? 1 : h, 1'b1);
    end
    quiet = 1'b0;

    // top of the height register, replaced before any pixel is sent
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);

    // short frame at a middle size to close
    set_frame_size(5, 3);
    push_frame(5, 3, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (smooth_due.size() != 0) begin
      mismatch_count += smooth_due.size();
      $error("%0d expected results never arrived", smooth_due.size());
    end
    $display("Run: %0d pixel/flush transfers, %0d results checked, %0d frames, %0d reg writes",
             items_taken, results_seen, frames_seen, reg_writes);
    $display("Frames from 1x1 up to 9x6 with stray flushes, tail data, hold-off and pauses");
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
